// ===== rtl/smd_pkg.sv =====
package smd_pkg;

    localparam int unsigned CODE_W = 24;
    localparam int unsigned REPLY_W = 56;

    typedef logic [3:0] t_verdict;

    localparam t_verdict V_WRONG_NI = 4'd0;
    localparam t_verdict V_NOT_FOR_US = 4'd1;
    localparam t_verdict V_TO_ISUP = 4'd2;
    localparam t_verdict V_TEST_REPLY = 4'd3;
    localparam t_verdict V_TEST_ACK = 4'd4;
    localparam t_verdict V_BAD_TEST = 4'd5;
    localparam t_verdict V_RESTART = 4'd6;
    localparam t_verdict V_OTHER_MGMT = 4'd7;
    localparam t_verdict V_UNSUPPORTED = 4'd8;

    localparam logic [3:0] UP_MGMT = 4'd0;
    localparam logic [3:0] UP_TEST = 4'd1;
    localparam logic [3:0] UP_TEST_SPECIAL = 4'd2;
    localparam logic [3:0] UP_ISUP = 4'd5;

    localparam logic [3:0] H0_TEST = 4'd1;
    localparam logic [3:0] H0_MGMT_TRA = 4'd7;
    localparam logic [3:0] H1_SLTM = 4'd1;
    localparam logic [3:0] H1_SLTA = 4'd2;
    localparam logic [3:0] H1_TRA = 4'd1;

    localparam logic [2:0] LABEL_ITU = 3'd4;
    localparam logic [2:0] LABEL_ANSI = 3'd7;

    typedef logic [1:0] t_link_state;
    localparam t_link_state LS_DOWN = 2'd0;
    localparam t_link_state LS_UP = 2'd3;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SWITCH_IS_ITU = 2'd0;
    localparam t_cfg_index CFG_NETWORK_IND = 2'd1;
    localparam t_cfg_index CFG_OWN_CODE = 2'd2;

    typedef struct packed {
        t_verdict verdict;
        logic [CODE_W-1:0] origin_code;
        logic [CODE_W-1:0] destination_code;
        logic [7:0] link_selection;
        logic [2:0] label_size;
        logic [3:0] test_pattern_length;
        logic [REPLY_W-1:0] reply_label;
        logic mark_up;
        logic restart;
    } t_dec;

endpackage

// ===== rtl/smd_decode.sv =====
module smd_decode (
    input  logic        i_itu,
    input  logic [1:0]  i_ni,
    input  logic [23:0] i_own,
    input  logic [7:0]  i_sio,
    input  logic [7:0]  i_b0,
    input  logic [7:0]  i_b1,
    input  logic [7:0]  i_b2,
    input  logic [7:0]  i_b3,
    input  logic [7:0]  i_b4,
    input  logic [7:0]  i_b5,
    input  logic [7:0]  i_b6,
    input  logic [7:0]  i_b7,
    input  logic [7:0]  i_b8,
    output smd_pkg::t_dec o_dec
);

    logic [23:0] dpc;
    logic [23:0] opc;
    logic [7:0]  sls;
    logic [23:0] own;
    logic [7:0]  hdr;
    logic [7:0]  lenb;
    logic [3:0]  h0;
    logic [3:0]  h1;
    logic [3:0]  upart;

    always_comb begin
        if (i_itu) begin
            dpc = {10'd0, i_b1[5:0], i_b0};
            opc = {10'd0, i_b3[3:0], i_b2, i_b1[7:6]};
            sls = {4'd0, i_b3[7:4]};
            own = {10'd0, i_own[13:0]};
            hdr = i_b4;
            lenb = i_b5;
        end else begin
            dpc = {i_b2, i_b1, i_b0};
            opc = {i_b5, i_b4, i_b3};
            sls = i_b6;
            own = i_own;
            hdr = i_b7;
            lenb = i_b8;
        end
    end

    assign h0 = hdr[3:0];
    assign h1 = hdr[7:4];
    assign upart = i_sio[3:0];

    always_comb begin
        o_dec = '0;
        o_dec.origin_code = opc;
        o_dec.destination_code = dpc;
        o_dec.link_selection = sls;
        o_dec.label_size = i_itu ? smd_pkg::LABEL_ITU : smd_pkg::LABEL_ANSI;

        if (i_sio[7:6] != i_ni) begin
            o_dec.verdict = smd_pkg::V_WRONG_NI;
        end else if (dpc != own) begin
            o_dec.verdict = smd_pkg::V_NOT_FOR_US;
        end else if (upart == smd_pkg::UP_TEST || upart == smd_pkg::UP_TEST_SPECIAL) begin
            if (h0 != smd_pkg::H0_TEST) begin
                o_dec.verdict = smd_pkg::V_BAD_TEST;
            end else if (h1 == smd_pkg::H1_SLTM) begin
                o_dec.verdict = smd_pkg::V_TEST_REPLY;
                o_dec.test_pattern_length = lenb[7:4];
                o_dec.mark_up = 1'b1;
                // The reply swaps the codes: our code becomes the origin.
                if (i_itu) begin
                    o_dec.reply_label = {24'd0, sls[3:0], own[13:10], own[9:2],
                                         own[1:0], opc[13:8], opc[7:0]};
                end else begin
                    o_dec.reply_label = {sls, own, opc};
                end
            end else if (h1 == smd_pkg::H1_SLTA) begin
                o_dec.verdict = smd_pkg::V_TEST_ACK;
            end else begin
                o_dec.verdict = smd_pkg::V_BAD_TEST;
            end
        end else if (upart == smd_pkg::UP_ISUP) begin
            o_dec.verdict = smd_pkg::V_TO_ISUP;
        end else if (upart == smd_pkg::UP_MGMT) begin
            if (h0 == smd_pkg::H0_MGMT_TRA && h1 == smd_pkg::H1_TRA) begin
                o_dec.verdict = smd_pkg::V_RESTART;
                o_dec.mark_up = 1'b1;
                o_dec.restart = 1'b1;
            end else begin
                o_dec.verdict = smd_pkg::V_OTHER_MGMT;
            end
        end else begin
            o_dec.verdict = smd_pkg::V_UNSUPPORTED;
        end
    end

endmodule

// ===== rtl/smd_link_table.sv =====
module smd_link_table #(
    parameter int unsigned LINKS = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  smd_pkg::t_link_state i_wr_data,
    output smd_pkg::t_link_state o_rd_data
);

    smd_pkg::t_link_state r_mem [LINKS];
    logic [LINKS-1:0]     r_written;
    smd_pkg::t_link_state r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    // A read of the entry being written in the same cycle sees the new value.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_addr == i_rd_addr) begin
                r_rd_data <= i_wr_data;
            end else if (r_written[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= smd_pkg::LS_DOWN;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/signalling_message_discriminator_unit.sv =====
// Signalling message discriminator: takes one message header per item (link,
// service octet and the first nine signalling field bytes), parses the ITU or
// ANSI routing label, checks network indicator and destination, and returns one
// result item per input item. It accepts one item per cycle while not stalled. An item
// accepted at a clock edge sits in the first stage while the registered read of
// the per-link state memory completes, and moves into the output register once
// the output is free, where the link state is written back; the result is offered
// from then on. A stalled output holds the first stage, which in turn stalls the
// input in the same cycle. The network-up latch and the link table are updated in
// item order, so results are exact for any back-to-back sequence. Configuration
// is written through the plain write port; the user must do so only while no item
// is in flight, which the block itself does not enforce.
module signalling_message_discriminator_unit #(
    parameter int unsigned LINKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_link_index,
    input  logic [7:0]  i_sio,
    input  logic [7:0]  i_sif_byte_0,
    input  logic [7:0]  i_sif_byte_1,
    input  logic [7:0]  i_sif_byte_2,
    input  logic [7:0]  i_sif_byte_3,
    input  logic [7:0]  i_sif_byte_4,
    input  logic [7:0]  i_sif_byte_5,
    input  logic [7:0]  i_sif_byte_6,
    input  logic [7:0]  i_sif_byte_7,
    input  logic [7:0]  i_sif_byte_8,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_verdict,
    output logic [23:0] o_origin_code,
    output logic [23:0] o_destination_code,
    output logic [7:0]  o_link_selection,
    output logic [2:0]  o_label_size,
    output logic [3:0]  o_test_pattern_length,
    output logic [55:0] o_reply_label,
    output logic        o_network_up_event
);

    localparam int unsigned IDX_W = (LINKS > 1) ? $clog2(LINKS) : 1;

    logic               r_itu;
    logic [1:0]         r_ni;
    logic [23:0]        r_own;

    smd_pkg::t_dec      dec;
    logic               accept;
    logic               s1_move;
    logic               out_free;
    logic [6:0]         link_ext;
    logic [IDX_W-1:0]   rd_addr;
    logic               tbl_wr;
    smd_pkg::t_link_state rd_data;
    logic               ev;

    logic               r_s1_valid;
    smd_pkg::t_dec      r_s1_dec;
    logic [IDX_W-1:0]   r_s1_idx;
    logic               r_s1_in_range;
    logic               r_network_up;
    logic               n_network_up;

    logic               r_out_valid;
    smd_pkg::t_dec      r_out_dec;
    logic               r_out_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_itu <= 1'b1;
            r_ni <= '0;
            r_own <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                smd_pkg::CFG_SWITCH_IS_ITU: r_itu <= i_cfg_wdata[0];
                smd_pkg::CFG_NETWORK_IND:   r_ni <= i_cfg_wdata[1:0];
                smd_pkg::CFG_OWN_CODE:      r_own <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    smd_decode u_decode (
        .i_itu (r_itu),
        .i_ni  (r_ni),
        .i_own (r_own),
        .i_sio (i_sio),
        .i_b0  (i_sif_byte_0),
        .i_b1  (i_sif_byte_1),
        .i_b2  (i_sif_byte_2),
        .i_b3  (i_sif_byte_3),
        .i_b4  (i_sif_byte_4),
        .i_b5  (i_sif_byte_5),
        .i_b6  (i_sif_byte_6),
        .i_b7  (i_sif_byte_7),
        .i_b8  (i_sif_byte_8),
        .o_dec (dec)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign s1_move = r_s1_valid && out_free;
    assign o_stall = r_s1_valid && !out_free;
    assign accept = i_valid && !o_stall;

    assign link_ext = {3'd0, i_link_index};
    assign rd_addr = link_ext[IDX_W-1:0];

    // Write back only when the entry is not already up.
    assign tbl_wr = s1_move && r_s1_dec.mark_up && r_s1_in_range
                    && (rd_data != smd_pkg::LS_UP);

    smd_link_table #(
        .LINKS (LINKS),
        .IDX_W (IDX_W)
    ) u_link_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (smd_pkg::LS_UP),
        .o_rd_data (rd_data)
    );

    assign ev = r_s1_dec.mark_up && !r_network_up;

    always_comb begin
        n_network_up = r_network_up;
        if (s1_move && r_s1_dec.restart) begin
            n_network_up = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_network_up <= 1'b0;
        end else begin
            r_network_up <= n_network_up;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dec <= dec;
            r_s1_idx <= rd_addr;
            r_s1_in_range <= (link_ext < 7'(LINKS));
        end
        if (s1_move) begin
            r_out_dec <= r_s1_dec;
            r_out_ev <= ev;
        end
    end

    assign o_valid = r_out_valid;
    assign o_verdict = r_out_dec.verdict;
    assign o_origin_code = r_out_dec.origin_code;
    assign o_destination_code = r_out_dec.destination_code;
    assign o_link_selection = r_out_dec.link_selection;
    assign o_label_size = r_out_dec.label_size;
    assign o_test_pattern_length = r_out_dec.test_pattern_length;
    assign o_reply_label = r_out_dec.reply_label;
    assign o_network_up_event = r_out_ev;

    // Once latched, the network stays up until reset.
    a_network_up_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_network_up |=> r_network_up)
        else $error("network up latch dropped");

    // An event is raised only by a good test or a restart.
    a_event_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_network_up_event) |->
        (o_verdict == smd_pkg::V_TEST_REPLY || o_verdict == smd_pkg::V_RESTART))
        else $error("network-up event on wrong verdict");

    // A restart that leaves the first stage has latched the network up.
    a_restart_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_dec.restart) |=> r_network_up)
        else $error("restart did not latch network up");

    // An item that marks a link up while the network is already up raises no event.
    a_event_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_dec.mark_up && r_network_up) |=> !r_out_ev)
        else $error("event raised while network up");

endmodule
